// ===== src/fdt_pkg.sv =====
// ----------------------------------------------------------------------------
// fdt_pkg
// Shared types and constants of the fixed 8.8 to decimal text unit.
// ----------------------------------------------------------------------------
package fdt_pkg;

   localparam int VALUE_W     = 16;
   localparam int FRAC_W      = 8;
   localparam int DIGIT_W     = 4;
   localparam int CHAR_W      = 6;
   localparam int POS_W       = 3;
   localparam int QUEUE_DEPTH = 4;

   // Character positions in the text of one value.
   localparam logic [POS_W-1:0] POS_HUNDREDS = 3'd0;
   localparam logic [POS_W-1:0] POS_TENS     = 3'd1;
   localparam logic [POS_W-1:0] POS_UNITS    = 3'd2;
   localparam logic [POS_W-1:0] POS_POINT    = 3'd3;
   localparam logic [POS_W-1:0] POS_TENTHS   = 3'd4;
   localparam logic [POS_W-1:0] POS_HUNDTHS  = 3'd5;
   localparam logic [POS_W-1:0] POS_THOUTHS  = 3'd6;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [CHAR_W-1:0] CHAR_POINT = 6'd46;

   typedef struct packed {
      logic [POS_W-1:0]   start_pos;
      logic [DIGIT_W-1:0] hundreds;
      logic [DIGIT_W-1:0] tens;
      logic [DIGIT_W-1:0] units;
      logic [DIGIT_W-1:0] tenths;
      logic [DIGIT_W-1:0] hundths;
      logic [DIGIT_W-1:0] thouths;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

endpackage

// ===== src/fdt_front.sv =====
// ----------------------------------------------------------------------------
// fdt_front
// Splits an 8.8 value into integer and fraction digits and picks the first
// position to print.
// ----------------------------------------------------------------------------
module fdt_front (
   input  logic [fdt_pkg::VALUE_W-1:0] value,
   output fdt_pkg::entry_type          entry
);

   logic [11:0] bcd;
   logic [7:0]  int_part;
   logic [7:0]  frac_part;
   logic [11:0] prod1;
   logic [11:0] prod2;
   logic [11:0] prod3;

   // Integer byte to BCD by shift and add-3.
   always_comb begin
      int_part = value[fdt_pkg::VALUE_W-1:fdt_pkg::FRAC_W];
      bcd      = 12'd0;
      for (int i = 0; i < 8; i++) begin
         if (bcd[3:0] >= 4'd5) begin
            bcd[3:0] = bcd[3:0] + 4'd3;
         end
         if (bcd[7:4] >= 4'd5) begin
            bcd[7:4] = bcd[7:4] + 4'd3;
         end
         bcd = {bcd[10:0], int_part[7-i]};
      end
   end

   // Each fraction digit is the carry out of the byte when multiplied by ten.
   always_comb begin
      frac_part = value[fdt_pkg::FRAC_W-1:0];
      prod1     = {1'b0, frac_part, 3'b000} + {3'b000, frac_part, 1'b0};
      prod2     = {1'b0, prod1[7:0], 3'b000} + {3'b000, prod1[7:0], 1'b0};
      prod3     = {1'b0, prod2[7:0], 3'b000} + {3'b000, prod2[7:0], 1'b0};
   end

   always_comb begin
      entry.hundreds = bcd[11:8];
      entry.tens     = bcd[7:4];
      entry.units    = bcd[3:0];
      entry.tenths   = prod1[11:8];
      entry.hundths  = prod2[11:8];
      entry.thouths  = prod3[11:8];
      if (bcd[11:8] != 4'd0) begin
         entry.start_pos = fdt_pkg::POS_HUNDREDS;
      end else if (bcd[7:4] != 4'd0) begin
         entry.start_pos = fdt_pkg::POS_TENS;
      end else begin
         entry.start_pos = fdt_pkg::POS_UNITS;
      end
   end

endmodule

// ===== src/fdt_queue.sv =====
// ----------------------------------------------------------------------------
// fdt_queue
// Small first-in first-out queue of classified values between the front
// and the character sequencer.
// ----------------------------------------------------------------------------
module fdt_queue #(
   parameter int DEPTH = fdt_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  fdt_pkg::entry_type push_entry,
   output fdt_pkg::head_type  head,
   input  logic               pop
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   fdt_pkg::entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;

   always_comb begin
      push_ready = (count_ff != CNT_W'(DEPTH));
      push       = push_valid && push_ready;
      head.valid = (count_ff != '0);
      head.entry = entries_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== src/fdt_back.sv =====
// ----------------------------------------------------------------------------
// fdt_back
// Character sequencer: walks the positions of the value at the queue head
// and drives one character per cycle into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module fdt_back (
   input  logic                         clock,
   input  logic                         reset,
   input  fdt_pkg::head_type            head,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [fdt_pkg::CHAR_W-1:0]   rsp_char,
   output logic                         rsp_last
);

   logic [fdt_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic                       started_ff, started_in;
   logic                       valid_ff, valid_in;
   logic [fdt_pkg::CHAR_W-1:0] char_ff, char_in;
   logic                       last_ff, last_in;
   logic [fdt_pkg::POS_W-1:0]  cur_pos;
   logic [fdt_pkg::DIGIT_W-1:0] digit;
   logic                       advance;
   logic                       fire;

   always_comb begin
      cur_pos = started_ff ? pos_ff : head.entry.start_pos;
      advance = !valid_ff || rsp_ready;
      fire    = advance && head.valid;
      pop     = fire && (cur_pos == fdt_pkg::POS_THOUTHS);

      unique case (cur_pos)
         fdt_pkg::POS_HUNDREDS: digit = head.entry.hundreds;
         fdt_pkg::POS_TENS:     digit = head.entry.tens;
         fdt_pkg::POS_UNITS:    digit = head.entry.units;
         fdt_pkg::POS_TENTHS:   digit = head.entry.tenths;
         fdt_pkg::POS_HUNDTHS:  digit = head.entry.hundths;
         fdt_pkg::POS_THOUTHS:  digit = head.entry.thouths;
         default:               digit = '0;
      endcase

      valid_in   = advance ? head.valid : valid_ff;
      char_in    = char_ff;
      last_in    = last_ff;
      pos_in     = pos_ff;
      started_in = started_ff;
      if (fire) begin
         char_in = (cur_pos == fdt_pkg::POS_POINT) ? fdt_pkg::CHAR_POINT
                 : fdt_pkg::CHAR_ZERO + {2'b00, digit};
         last_in = pop;
         if (pop) begin
            started_in = 1'b0;
         end else begin
            started_in = 1'b1;
            pos_in     = cur_pos + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         started_ff <= 1'b0;
         pos_ff     <= fdt_pkg::POS_HUNDREDS;
      end else begin
         valid_ff   <= valid_in;
         started_ff <= started_in;
         pos_ff     <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_char  = char_ff;
   assign rsp_last  = last_ff;

endmodule

// ===== src/fixed_8_8_to_decimal_text_unit.sv =====
// ----------------------------------------------------------------------------
// fixed_8_8_to_decimal_text_unit
// Converts unsigned 8.8 fixed-point values into ASCII decimal text.
// ----------------------------------------------------------------------------
// Each accepted value produces five to seven characters: one to three integer
// digits without leading zeros, a '.', and three fractional digits truncated
// to thousandths; tlast marks the final character. The result channel sends
// one character per cycle while rsp_tready is high, from a registered output
// driven by the character sequencer. Input transactions are taken whenever
// the queue of QUEUE_DEPTH classified values has room, so the input side
// keeps working while earlier text is still going out.
module fixed_8_8_to_decimal_text_unit #(
   parameter int QUEUE_DEPTH = fdt_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [5:0] character, [7:6] zero
   output logic        rsp_tlast
);

   fdt_pkg::entry_type          front_entry;
   fdt_pkg::head_type           head;
   logic                        pop;
   logic [fdt_pkg::CHAR_W-1:0]  rsp_char;

   fdt_front u_front (
      .value (req_tdata),
      .entry (front_entry)
   );

   fdt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_entry (front_entry),
      .head       (head),
      .pop        (pop)
   );

   fdt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_char  (rsp_char),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, rsp_char};

   // The sequencer only retires a queue entry that is present.
   assert property (@(posedge clock) disable iff (reset) pop |-> head.valid)
      else $error("queue popped while empty");

   // The final character of a value is always a digit, never the point.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_char != fdt_pkg::CHAR_POINT)
      else $error("text ended on the point");

   // Characters are digits or the point only.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_char == fdt_pkg::CHAR_POINT)
                  || ((rsp_char >= fdt_pkg::CHAR_ZERO) && (rsp_char <= 6'd57)))
      else $error("character out of range");

   // Nothing is offered right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fixed 8.8 to decimal text unit.
// ----------------------------------------------------------------------------
// Values are pushed into the request stream and every accepted value is
// turned into its expected characters by a local predictor. Characters that
// come out of the response stream are compared in order against that text.
// The run goes from a directed set of boundary values to three random phases
// with different idle mixes, one long output hold-off and drain pauses.
// ----------------------------------------------------------------------------
module tb;

   localparam int          VALUE_W       = fdt_pkg::VALUE_W;
   localparam int          CHAR_W        = fdt_pkg::CHAR_W;
   localparam int          CLK_HALF      = 5;
   localparam int          RESET_CYCLES  = 8;
   localparam int          PHASE_ITEMS   = 118;
   localparam int          HOLD_AT       = 40;
   localparam int          HOLD_CYCLES   = 150;
   localparam int          STALL_LIMIT   = 3000;
   localparam int          SETTLE_CYCLES = 20;
   localparam int unsigned THOUSANDTHS_MUL = 15625;
   localparam int unsigned THOUSANDTHS_DIV = 4000;
   localparam int unsigned TOP_ORDER       = 100000;
   localparam int unsigned UNITS_ORDER     = 1000;
   localparam int unsigned POINT_ORDER     = 100;
   localparam int          MAX_REPORTS     = 10;

   typedef struct {
      logic [CHAR_W-1:0] character;
      logic              last;
   } text_char_type;

   class text_scoreboard;
      text_char_type pending_text[$];
      int            values_noted;
      int            chars_checked;
      int            mismatches;
      int            int_digits[1:3];

      function new();
         values_noted  = 0;
         chars_checked = 0;
         mismatches    = 0;
         int_digits    = '{0, 0, 0};
      endfunction

      function int pending();
         return pending_text.size();
      endfunction

      // Expands one accepted value into the characters it should produce.
      function void note_value(logic [VALUE_W-1:0] value);
         int unsigned   thousandths;
         int unsigned   order;
         int unsigned   digit;
         bit            started;
         int            printed;
         text_char_type tc;
         thousandths = value * THOUSANDTHS_MUL / THOUSANDTHS_DIV;
         order       = TOP_ORDER;
         started     = 1'b0;
         printed     = 0;
         tc.last     = 1'b0;
         while (order != 0) begin
            if (thousandths >= order || started || order <= UNITS_ORDER) begin
               digit        = thousandths / order;
               tc.character = fdt_pkg::CHAR_ZERO + CHAR_W'(digit);
               pending_text.push_back(tc);
               thousandths -= digit * order;
               started      = 1'b1;
               printed++;
            end
            order = order / 10;
            if (order == POINT_ORDER) begin
               tc.character = fdt_pkg::CHAR_POINT;
               pending_text.push_back(tc);
            end
         end
         pending_text[$].last = 1'b1;
         int_digits[printed - 3]++;
         values_noted++;
      endfunction

      function void check_char(logic [7:0] data, logic last);
         text_char_type want;
         chars_checked++;
         if (pending_text.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected character 0x%02h last=%0b", $time, data, last);
         end else begin
            want = pending_text.pop_front();
            if (data !== {2'b00, want.character} || last !== want.last) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"%0t: character mismatch: expected 0x%02h last=%0b,",
                            " got 0x%02h last=%0b"},
                           $time, {2'b00, want.character}, want.last, data, last);
            end
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [15:0]        req_tdata = '0;   // [15:0] value
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [7:0]         rsp_tdata;        // [5:0] character, [7:6] zero
   logic               rsp_tlast;

   text_scoreboard     sb = new();
   int                 send_idle_pct = 0;
   int                 recv_idle_pct = 0;
   int                 hold_left = 0;
   bit                 hold_done = 1'b0;
   int                 stall_cycles = 0;

   fixed_8_8_to_decimal_text_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // Both streams are observed at the rising edge, before the block updates.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_value(req_tdata);
         if (rsp_tvalid && rsp_tready)
            sb.check_char(rsp_tdata, rsp_tlast);
      end
   end

   // Response side ready; once in the run it holds off long enough for the
   // block to fill up and push back on the request stream.
   always @(negedge clock) begin
      if (!hold_done && sb.values_noted >= HOLD_AT) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d characters outstanding",
                  $time, stall_cycles, sb.pending());
         $display("FAIL fixed_8_8_to_decimal_text_unit");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_value(input logic [VALUE_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Stops offering values until all outstanding text has come out.
   task automatic drain_text();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      logic [7:0] frac;
      frac = 8'($urandom);
      case ($urandom_range(5))
         0: return VALUE_W'($urandom);
         1: return {8'($urandom_range(9)), frac};
         2: return {8'($urandom_range(9, 10)), frac};
         3: return {8'($urandom_range(99, 100)), frac};
         4: return {8'($urandom_range(100, 255)), frac};
         default: begin
            case ($urandom_range(3))
               0: frac = 8'h00;
               1: frac = 8'h01;
               2: frac = 8'h80;
               default: frac = 8'hFF;
            endcase
            return {8'($urandom), frac};
         end
      endcase
   endfunction

   logic [VALUE_W-1:0] boundary_values[] = '{
      16'h0000, 16'hFFFF, 16'h0001, 16'h00FF, 16'h0080, 16'h0040,
      16'h0100, 16'h0900, 16'h09FF, 16'h0A00, 16'h0A01, 16'h6300,
      16'h63FF, 16'h6400, 16'h6401, 16'hFF00, 16'h8000, 16'h7FFF,
      16'hAAAA, 16'h5555, 16'h0005, 16'h0C80
   };

   initial begin
      send_idle_pct = 32;
      recv_idle_pct = 78;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      foreach (boundary_values[i])
         send_value(boundary_values[i]);
      drain_text();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 32; recv_idle_pct = 78; end
            1: begin send_idle_pct = 78; recv_idle_pct = 32; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         repeat (PHASE_ITEMS)
            send_value(pick_value());
         drain_text();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);

      $display({"Converted %0d values into %0d characters;",
                " integer parts of 1/2/3 digits: %0d/%0d/%0d."},
               sb.values_noted, sb.chars_checked,
               sb.int_digits[1], sb.int_digits[2], sb.int_digits[3]);
      $display("Flow control covered three idle mixes, a %0d-cycle output hold-off and drains.",
               HOLD_CYCLES);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASS fixed_8_8_to_decimal_text_unit");
      end else begin
         $display("%0d mismatches, %0d characters never arrived", sb.mismatches, sb.pending());
         $display("FAIL fixed_8_8_to_decimal_text_unit");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/fdt_pkg.sv
src/fdt_front.sv
src/fdt_queue.sv
src/fdt_back.sv
src/fixed_8_8_to_decimal_text_unit.sv
tb/tb.sv
